/* rtl/mexp_pkg.sv */
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int OperandWidthDefault = 32;
  localparam int FieldWidth = 32;

endpackage

/* rtl/mexp_cell.sv */
`timescale 1ns / 1ps

module mexp_cell #(
  parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [OPERAND_WIDTH-1:0] in_acc,
  input  logic [OPERAND_WIDTH-1:0] in_a,
  input  logic [OPERAND_WIDTH-1:0] in_b,
  input  logic [OPERAND_WIDTH-1:0] in_m,
  output logic                     out_valid,
  output logic [OPERAND_WIDTH-1:0] out_acc,
  output logic [OPERAND_WIDTH-1:0] out_a,
  output logic [OPERAND_WIDTH-1:0] out_b,
  output logic [OPERAND_WIDTH-1:0] out_m
);

  localparam int W = OPERAND_WIDTH;

  logic [W:0]   dbl_sum;
  logic [W-1:0] dbl;
  logic [W:0]   add_sum;
  logic [W-1:0] acc_next;

  // one doubling and one conditional add, both modulo m
  always_comb begin
    dbl_sum = {1'b0, in_acc} + {1'b0, in_acc};
    dbl     = (dbl_sum >= {1'b0, in_m}) ? W'(dbl_sum - {1'b0, in_m}) : dbl_sum[W-1:0];
    add_sum = {1'b0, dbl} + {1'b0, in_a};
    if (in_b[W-1]) begin
      acc_next = (add_sum >= {1'b0, in_m}) ? W'(add_sum - {1'b0, in_m}) : add_sum[W-1:0];
    end else begin
      acc_next = dbl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_acc <= acc_next;
    out_a   <= in_a;
    out_b   <= {in_b[W-2:0], 1'b0};
    out_m   <= in_m;
  end

endmodule

/* rtl/mexp_mul_chain.sv */
`timescale 1ns / 1ps

module mexp_mul_chain #(
  parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  logic [OPERAND_WIDTH-1:0] in_a,
  input  logic [OPERAND_WIDTH-1:0] in_b,
  input  logic [OPERAND_WIDTH-1:0] in_m,
  output logic                     out_valid,
  output logic [OPERAND_WIDTH-1:0] out_acc
);

  localparam int W = OPERAND_WIDTH;

  logic         v   [W+1];
  logic [W-1:0] acc [W+1];
  logic [W-1:0] a   [W+1];
  logic [W-1:0] b   [W+1];
  logic [W-1:0] m   [W+1];

  assign v[0]   = in_valid;
  assign acc[0] = '0;
  assign a[0]   = in_a;
  assign b[0]   = in_b;
  assign m[0]   = in_m;

  // cell k handles multiplier bit W-1-k
  for (genvar k = 0; k < W; k++) begin : g_cell
    mexp_cell #(.OPERAND_WIDTH(W)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (v[k]),
      .in_acc   (acc[k]),
      .in_a     (a[k]),
      .in_b     (b[k]),
      .in_m     (m[k]),
      .out_valid(v[k+1]),
      .out_acc  (acc[k+1]),
      .out_a    (a[k+1]),
      .out_b    (b[k+1]),
      .out_m    (m[k+1])
    );
  end

  assign out_valid = v[W];
  assign out_acc   = acc[W];

endmodule

/* rtl/modular_exponentiation_unit.sv */
`timescale 1ns / 1ps

// Computes base^exponent mod modulus by left-to-right square and multiply.
// Each modular product runs through a chain of OPERAND_WIDTH cells, one
// multiplier bit per cell. An item needs one reduction of the base,
// OPERAND_WIDTH squarings and one multiply per set exponent bit. A zero
// modulus returns residue zero with the error flag set. One item is in
// flight at a time; the next word is taken once the result has gone.
module modular_exponentiation_unit #(
  parameter int OPERAND_WIDTH = mexp_pkg::OperandWidthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,  // base_value, exponent_value, modulus_value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // power_residue
  output logic        m_tuser   // zero_modulus_error
);

  localparam int W  = OPERAND_WIDTH;
  localparam int FW = mexp_pkg::FieldWidth;
  localparam int CW = $clog2(W);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RED  = 3'd1;
  localparam logic [2:0] S_SQ   = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]    state;
  logic [W-1:0]  base_in, exp_in, mod_in, one_in;
  logic [W-1:0]  m, expo, res, b_red, op_a, op_b;
  logic [CW-1:0] cnt;
  logic          go, err;
  logic          c_valid;
  logic [W-1:0]  c_acc;

  assign base_in = W'({{W{1'b0}}, s_tdata[FW-1:0]});
  assign exp_in  = W'({{W{1'b0}}, s_tdata[2*FW-1:FW]});
  assign mod_in  = W'({{W{1'b0}}, s_tdata[3*FW-1:2*FW]});
  assign one_in  = (mod_in == W'(1)) ? '0 : W'(1);

  mexp_mul_chain #(.OPERAND_WIDTH(W)) u_chain (
    .clk      (clk),
    .rst      (rst),
    .in_valid (go),
    .in_a     (op_a),
    .in_b     (op_b),
    .in_m     (m),
    .out_valid(c_valid),
    .out_acc  (c_acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      go    <= 1'b0;
    end else begin
      go <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            m    <= mod_in;
            expo <= exp_in;
            cnt  <= CW'(W - 1);
            if (mod_in == '0) begin
              res   <= '0;
              err   <= 1'b1;
              state <= S_OUT;
            end else begin
              // base mod m by Horner over the base bits
              err   <= 1'b0;
              res   <= one_in;
              op_a  <= one_in;
              op_b  <= base_in;
              go    <= 1'b1;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if (c_valid) begin
            b_red <= c_acc;
            op_a  <= res;
            op_b  <= res;
            go    <= 1'b1;
            state <= S_SQ;
          end
        end
        S_SQ, S_MUL: begin
          if (c_valid) begin
            res <= c_acc;
            if (state == S_SQ && expo[W-1]) begin
              op_a  <= c_acc;
              op_b  <= b_red;
              go    <= 1'b1;
              state <= S_MUL;
            end else begin
              expo <= {expo[W-2:0], 1'b0};
              if (cnt == '0) begin
                state <= S_OUT;
              end else begin
                cnt   <= cnt - CW'(1);
                op_a  <= c_acc;
                op_b  <= c_acc;
                go    <= 1'b1;
                state <= S_SQ;
              end
            end
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = FW'({{FW{1'b0}}, res});
  assign m_tuser  = err;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [mexp_pkg::FieldWidth-1:0] residue;
    logic                            zero_mod;
  } residue_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;  // base_value, exponent_value, modulus_value
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;  // power_residue
  logic        m_tuser;  // zero_modulus_error

  residue_t pending_residues[$];
  int       mismatches = 0;
  int       hold = 0;
  bit       calm = 0;
  longint   cycles = 0;

  localparam longint CycleLimit = 3000000;

  modular_exponentiation_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic residue_t power_mod(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    residue_t r;
    longint unsigned acc;
    longint unsigned bb;
    r.zero_mod = (m == 0);
    r.residue = '0;
    if (m != 0) begin
      bb = b % m;
      acc = 64'd1 % m;
      for (int i = 31; i >= 0; i--) begin
        acc = (acc * acc) % m;
        if (e[i]) acc = (acc * bb) % m;
      end
      r.residue = acc[31:0];
    end
    return r;
  endfunction

  task automatic send_word(logic [31:0] b, logic [31:0] e, logic [31:0] m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {m, e, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_residues.push_back(power_mod(b, e, m));
  endtask

  // result side: per-word stall, checked against oldest expectation
  always @(posedge clk) begin
    residue_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_residues.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected word: residue %h err %b", m_tdata, m_tuser);
        end else begin
          want = pending_residues.pop_front();
          if (want.residue !== m_tdata || want.zero_mod !== m_tuser) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp residue %h err %b, got residue %h err %b",
                       want.residue, want.zero_mod, m_tdata, m_tuser);
          end
        end
        hold = calm ? 0 : $urandom_range(0, 5);
      end else if (m_tvalid && hold > 0) begin
        hold--;
      end
      m_tready <= (hold == 0);
    end
  end

  task automatic test_directed();
    calm = 1;
    send_word(32'd5, 32'd3, 32'd0);
    send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd0);
    send_word(32'd7, 32'd0, 32'd1);
    send_word(32'd7, 32'd0, 32'd13);
    send_word(32'd0, 32'd0, 32'd13);
    send_word(32'd0, 32'd0, 32'hFFFFFFFF);
    send_word(32'd0, 32'd9, 32'd13);
    send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
    send_word(32'd123, 32'd456, 32'd1);
    send_word(32'd100, 32'd1, 32'd7);
    send_word(32'd13, 32'd5, 32'd13);
    send_word(32'd3, 32'd2, 32'd10);
    calm = 0;
    send_word(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(32'hFFFFFFFE, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_word(32'hFFFFFFFF, 32'h80000000, 32'hFFFFFFFB);
    send_word(32'h80000000, 32'hFFFFFFFF, 32'h7FFFFFFF);
    send_word(32'd2, 32'hFFFFFFFF, 32'd3);
    send_word(32'hDEADBEEF, 32'h00000001, 32'hFFFFFFFF);
    send_word(32'd2, 32'd31, 32'h80000000);
  endtask

  task automatic test_random();
    logic [31:0] b, e, m;
    for (int n = 0; n < 250; n++) begin
      calm = (n >= 100 && n < 130);
      b = $urandom;
      e = $urandom;
      m = $urandom;
      case ($urandom_range(0, 9))
        0: m = $urandom_range(1, 16);
        1: e = $urandom_range(0, 3);
        2: m = 0;
        3: b = m + $urandom_range(0, 3);
        default: ;
      endcase
      send_word(b, e, m);
    end
    calm = 0;
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    s_tvalid <= 1'b0;
    while (pending_residues.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

endmodule
